### hw/rtl/telemetry_field_decoder_assert.svh
// Assertion macros used by the telemetry field decoder RTL.
`ifndef TELEMETRY_FIELD_DECODER_ASSERT_SVH
`define TELEMETRY_FIELD_DECODER_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define TFD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Check an implication in the next cycle outside reset.
`define TFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

### hw/rtl/tfd_pkg.sv
// Package with modes, widths and the decode functions of the telemetry field decoder.
`timescale 1ns / 1ps
`default_nettype none
package tfd_pkg;
    localparam int unsigned AccW = 64;
    localparam int unsigned CntW = 7;

    typedef enum logic [2:0] {
        MODE_RAW   = 3'd0,
        MODE_TWOS  = 3'd1,
        MODE_ONES  = 3'd2,
        MODE_GRAY  = 3'd3,
        MODE_M1750_32 = 3'd4,
        MODE_M1750_48 = 3'd5
    } mode_t;

    // Accumulator snapshot handed from the collect stage to the decode stage.
    typedef struct packed {
        logic [AccW-1:0] acc;
        logic [CntW-1:0] cnt;
        logic            ovf;
    } field_t;

    function automatic logic [4:0] top_bit24(input logic [24:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 25; i++) if (v[i]) p = 5'(i);
        return p;
    endfunction

    function automatic logic [5:0] top_bit40(input logic [40:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 41; i++) if (v[i]) p = 6'(i);
        return p;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [6:0] n);
        logic [63:0] r;
        r = v;
        if (n != 7'd0 && n < 7'd64) begin
            for (int i = 0; i < 64; i++)
                if (i >= int'(n)) r[i] = v[n[5:0] - 6'd1];
        end
        return r;
    endfunction

    function automatic logic [63:0] gray_dec(input logic [63:0] a);
        logic [63:0] r;
        r[63] = a[63];
        for (int i = 62; i >= 0; i--) r[i] = r[i+1] ^ a[i];
        return r;
    endfunction

    function automatic logic [31:0] m32_to_single(input logic [31:0] w);
        logic [23:0] m24;
        logic        neg;
        logic [24:0] mag;
        logic [4:0]  p;
        logic signed [10:0] e, biased, k;
        logic [31:0] bits, q, rem, half, mask;
        logic [5:0]  sh;
        m24 = w[31:8];
        e = 11'(signed'(w[7:0]));
        neg = m24[23];
        mag = neg ? (25'h1000000 - {1'b0, m24}) : {1'b0, m24};
        bits = '0;
        if (mag != '0) begin
            p = top_bit24(mag);
            biased = 11'(p) + e + 11'sd104;
            if (biased >= 11'sd1) begin
                bits = {1'b0, biased[7:0], 23'(32'(mag) << (5'd23 - p))};
            end else begin
                k = e + 11'sd126;
                if (k >= 0) begin
                    bits = 32'(mag) << k[4:0];
                end else begin
                    sh = 6'(-k);
                    if (sh > 6'd31) sh = 6'd31;
                    q = 32'(mag) >> sh;
                    mask = (32'd1 << sh) - 32'd1;
                    rem = 32'(mag) & mask;
                    half = 32'd1 << (sh - 6'd1);
                    if (rem > half || (rem == half && q[0])) q = q + 32'd1;
                    bits = q;
                end
            end
            if (neg) bits[31] = 1'b1;
        end
        return bits;
    endfunction

    function automatic logic [63:0] m48_to_double(input logic [47:0] v);
        logic [39:0] m40;
        logic        neg;
        logic [40:0] mag;
        logic [5:0]  p;
        logic signed [11:0] biased;
        logic [63:0] bits;
        m40 = {v[47:24], v[15:0]};
        neg = m40[39];
        mag = neg ? (41'h10000000000 - {1'b0, m40}) : {1'b0, m40};
        bits = '0;
        if (mag != '0) begin
            p = top_bit40(mag);
            biased = 12'(p) + 12'(signed'(v[23:16])) + 12'sd984;
            bits = {1'b0, 11'(biased), 52'(64'(mag) << (6'd52 - p))};
            if (neg) bits[63] = 1'b1;
        end
        return bits;
    endfunction
endpackage
`default_nettype wire

### hw/rtl/tfd_decode.sv
// Decode stage: converts a collected field to its output value by mode.
`timescale 1ns / 1ps
`default_nettype none
module tfd_decode import tfd_pkg::*; (
    input  wire logic [2:0]  mode,
    input  wire field_t      fld,
    output logic [63:0]      value
);
    logic [63:0] sx;
    always_comb begin
        sx = sign_ext(fld.acc, fld.cnt);
        case (mode)
            MODE_TWOS: value = (fld.cnt == '0) ? '0 : sx;
            MODE_ONES: value = (fld.cnt == '0) ? '0 : sx + 64'(sx[63]);
            MODE_GRAY: value = gray_dec(fld.acc);
            MODE_M1750_32: value = {32'd0, m32_to_single(fld.acc[31:0])};
            MODE_M1750_48: value = m48_to_double(fld.acc[47:0]);
            default:   value = fld.acc;
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/telemetry_field_decoder.sv
// Top level of the telemetry field decoder: segment collector and result register.
// Usage:
//  - s_axis carries one segment per transaction. s_axis_tdata holds segment_byte,
//    first_bit and final_bit; s_axis_tlast marks the last segment of a field.
//  - Selected bits (MSB-first, inclusive range) shift into a 64-bit accumulator,
//    first segment most significant. Ranges with final_bit below first_bit add nothing.
//  - On a tlast segment the field is decoded by decode_mode and one result
//    transaction appears on m_axis: tdata holds decoded_value, field_bits, too_long.
//  - The result is registered: m_axis_tvalid rises in the cycle after the tlast segment is accepted.
//  - Throughput: one segment per cycle while s_axis_tready is high; each segment
//    passes the collect merge, and a tlast segment the decode logic into the output register.
//  - Stall: while m_axis_tready is low a pending result holds; s_axis_tready
//    stays high unless a held result would be overwritten by a new tlast
//    segment (non-last segments still flow).
//  - Reset (aresetn low, synchronous): clear the accumulator, count, overflow
//    flag, decode_mode and output valid.
//  - cfg_we writes decode_mode from cfg_wdata; use it only while the block is idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none
module telemetry_field_decoder import tfd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // segment_byte[7:0], first_bit[10:8], final_bit[13:11]
    input  wire logic        s_axis_tlast,  // last_segment
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata   // decoded_value[63:0], field_bits[70:64], too_long[71]
);
    `include "telemetry_field_decoder_assert.svh"

    logic [2:0]  mode_reg;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;
    logic        mv_reg;
    logic [71:0] mdata_reg;
    logic        accept;
    logic [7:0]  byte_in;
    logic [2:0]  fb, lb;
    logic [3:0]  n;
    logic [7:0]  bits_sel;
    logic [7:0]  cnt_sum;
    field_t      fld;
    logic [63:0] value;

    assign byte_in = s_axis_tdata[7:0];
    assign fb      = s_axis_tdata[10:8];
    assign lb      = s_axis_tdata[13:11];
    // Accept unless a tlast segment would clobber a held result.
    assign s_axis_tready = !(s_axis_tlast && mv_reg && !m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Merge this segment's bits below the accumulated ones.
    always_comb begin
        n = (lb >= fb) ? 4'({1'b0, lb} - {1'b0, fb} + 4'd1) : 4'd0;
        bits_sel = 8'((byte_in >> (3'd7 - lb)) & ((9'd1 << n) - 9'd1));
        acc_next = (n == 4'd0) ? acc_reg : ((acc_reg << n) | 64'(bits_sel));
        cnt_sum  = 8'(cnt_reg) + 8'(n);
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        if (n != 4'd0) begin
            if (cnt_sum > 8'd64) begin
                ovf_next = 1'b1;
                cnt_next = 7'd64;
            end else begin
                cnt_next = cnt_sum[6:0];
            end
        end
        fld.acc = acc_next;
        fld.cnt = cnt_next;
        fld.ovf = ovf_next;
    end

    tfd_decode u_decode (
        .mode  (mode_reg),
        .fld   (fld),
        .value (value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (m_axis_tready) begin
                mv_reg <= 1'b0;
            end
            if (accept) begin
                if (s_axis_tlast) begin
                    // Emit and clear the field state.
                    acc_reg <= '0;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                    mv_reg  <= 1'b1;
                end else begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_axis_tlast) begin
            mdata_reg <= {fld.ovf, fld.cnt, value};
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = mdata_reg;

    `TFD_ASSERT_NEXT(a_emit, aclk, aresetn, accept && s_axis_tlast, m_axis_tvalid)
    `TFD_ASSERT_NEXT(a_clear, aclk, aresetn, accept && s_axis_tlast,
        cnt_reg == '0 && !ovf_reg)
    `TFD_ASSERT_IMPL(a_cnt_cap, aclk, aresetn, 1'b1, cnt_reg <= 7'd64)
    `TFD_ASSERT_IMPL(a_ovf_full, aclk, aresetn, ovf_reg, cnt_reg == 7'd64)
endmodule
`default_nettype wire

### bench/telemetry_field_checker.sv
// Checker for the telemetry field decoder: watches both channels, predicts fields and compares.
`timescale 1ns / 1ps
module telemetry_field_checker import tfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_fields
);
    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  nbits;
        logic        ovf;
    } field_result_t;

    logic [63:0]   acc_bits;
    int unsigned   acc_count;
    logic          acc_ovf;
    logic [2:0]    mode_reg;
    field_result_t decoded_fields[$];

    function automatic int unsigned msb_pos(input logic [63:0] v);
        int unsigned p;
        p = 0;
        for (int i = 0; i < 64; i++) if (v[i]) p = i;
        return p;
    endfunction

    function automatic logic [63:0] extend_sign(input logic [63:0] v, input int unsigned n);
        logic [63:0] mask;
        if (n >= 64) return v;
        mask = (64'd1 << n) - 64'd1;
        return v[n-1] ? (v | ~mask) : (v & mask);
    endfunction

    function automatic logic [63:0] to_single(input logic [63:0] acc);
        logic [31:0] w, m24, mag, bits, q, rem, half;
        int e, biased, k, p, sh;
        logic neg;
        w = acc[31:0];
        m24 = {8'd0, w[31:8]};
        e = int'(w[7:0]) - (w[7] ? 256 : 0);
        neg = m24[23];
        mag = neg ? ((32'h1000000 - m24) & 32'hFFFFFF) : m24;
        if (neg && mag == 0) mag = 32'h800000;
        if (mag == 0) return 64'd0;
        p = msb_pos(64'(mag));
        biased = p + e + 104;
        if (biased >= 1) begin
            bits = (32'(biased) << 23) | ((mag << (23 - p)) & 32'h7FFFFF);
        end else begin
            k = e + 126;
            if (k >= 0) begin
                bits = mag << k;
            end else begin
                sh = -k;
                // shifts of 32 or more leave a zero quotient and no round-up
                q = (sh >= 32) ? 32'd0 : mag >> sh;
                rem = (sh >= 32) ? mag : mag & ((32'd1 << sh) - 1);
                half = (sh >= 33) ? 32'd0 : 32'd1 << (sh - 1);
                if (sh >= 33) begin
                    if (rem != 0) q = q;
                end else if (rem > half || (rem == half && q[0])) begin
                    q = q + 1;
                end
                bits = q;
            end
        end
        if (neg) bits[31] = 1'b1;
        return {32'd0, bits};
    endfunction

    function automatic logic [63:0] to_double(input logic [63:0] acc);
        logic [63:0] v, m40, mag, bits;
        int e, p;
        logic neg;
        v = acc & 64'hFFFFFFFFFFFF;
        e = int'(v[23:16]) - (v[23] ? 256 : 0);
        m40 = {v[47:24], v[15:0]};
        neg = m40[39];
        mag = neg ? ((64'd1 << 40) - m40) : m40;
        if (mag == 0) return 64'd0;
        p = msb_pos(mag);
        bits = (64'(32'(p + e + 984)) << 52) | ((mag << (52 - p)) & ((64'd1 << 52) - 1));
        if (neg) bits[63] = 1'b1;
        return bits;
    endfunction

    function automatic logic [63:0] decode_field(input logic [63:0] acc, input int unsigned n,
                                                 input logic [2:0] md);
        logic [63:0] v;
        case (md)
            MODE_TWOS: return (n == 0) ? 64'd0 : extend_sign(acc, n);
            MODE_ONES: begin
                if (n == 0) return 64'd0;
                v = extend_sign(acc, n);
                if (v[63]) v = v + 1;
                return v;
            end
            MODE_GRAY: begin
                v = acc;
                for (int i = 62; i >= 0; i--) v[i] = v[i+1] ^ acc[i];
                return v;
            end
            MODE_M1750_32: return to_single(acc);
            MODE_M1750_48: return to_double(acc);
            default: return acc;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_fields = decoded_fields.size();

    always @(posedge aclk) begin
        field_result_t exp_r;
        int unsigned n;
        logic [7:0] seg;
        logic [2:0] fb, lb;
        if (!aresetn) begin
            acc_bits = '0;
            acc_count = 0;
            acc_ovf = 0;
            mode_reg = MODE_RAW;
            decoded_fields.delete();
            fail_count = 0;
        end else begin
            // compare a result transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_fields.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
                end else begin
                    exp_r = decoded_fields.pop_front();
                    if (m_axis_tdata[63:0] !== exp_r.value)
                        report_mismatch("decoded_value", m_axis_tdata[63:0], exp_r.value);
                    if (m_axis_tdata[70:64] !== exp_r.nbits)
                        report_mismatch("field_bits", 64'(m_axis_tdata[70:64]), 64'(exp_r.nbits));
                    if (m_axis_tdata[71] !== exp_r.ovf)
                        report_mismatch("too_long", 64'(m_axis_tdata[71]), 64'(exp_r.ovf));
                end
            end
            // advance the field state on a segment transaction
            if (s_axis_tvalid && s_axis_tready) begin
                seg = s_axis_tdata[7:0];
                fb = s_axis_tdata[10:8];
                lb = s_axis_tdata[13:11];
                if (lb >= fb) begin
                    n = lb - fb + 1;
                    acc_bits = (acc_bits << n) | (64'(seg >> (7 - lb)) & ((64'd1 << n) - 1));
                    if (acc_count + n > 64) begin
                        acc_ovf = 1;
                        acc_count = 64;
                    end else begin
                        acc_count += n;
                    end
                end
                if (s_axis_tlast) begin
                    exp_r.value = decode_field(acc_bits, acc_count, mode_reg);
                    exp_r.nbits = 7'(acc_count);
                    exp_r.ovf = acc_ovf;
                    decoded_fields.push_back(exp_r);
                    acc_bits = 0;
                    acc_count = 0;
                    acc_ovf = 0;
                end
            end
            // the new mode applies from the next transaction on
            if (cfg_we) mode_reg = cfg_wdata;
        end
    end
endmodule

### bench/telemetry_field_decoder_tb.sv
// Testbench top for the telemetry field decoder: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module telemetry_field_decoder_tb import tfd_pkg::*;;
    localparam int StallLimit = 2000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // segment_byte[7:0], first_bit[10:8], final_bit[13:11]
    logic        s_axis_tlast;   // last_segment
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // decoded_value[63:0], field_bits[70:64], too_long[71]
    int          fail_count;
    int          pending_fields;
    int          idle_cycles;
    int          seg_count;
    bit          calm;           // stretch with no idling on either side

    telemetry_field_decoder uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    telemetry_field_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .fail_count(fail_count),
        .pending_fields(pending_fields)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Randomly stall the result side, except during the calm stretch.
    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(99) >= 33);
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("FAIL telemetry_field_decoder");
                $finish;
            end
        end
    end

    // Present one segment and hold it until accepted; idle first at random.
    task automatic send_segment(input logic [7:0] seg, input logic [2:0] fb,
                                input logic [2:0] lb, input logic lst);
        while (!calm && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, lb, fb, seg};
        s_axis_tlast <= lst;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        seg_count++;
    endtask

    // Drop valid, let the pipeline drain, then write the mode.
    task automatic set_mode(input logic [2:0] md);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_fields != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= md;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Send a field of full bytes, most significant first.
    task automatic send_word(input logic [63:0] w, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            send_segment(w[8*i +: 8], 3'd0, 3'd7, i == 0);
    endtask

    // One random field: mostly well-formed, with some reversed ranges and overlong runs.
    task automatic random_field(input logic [2:0] md);
        int nseg;
        logic [2:0] fb, lb;
        if (md == MODE_M1750_32 && $urandom_range(3) != 0) begin
            send_word({$urandom, $urandom}, 4);
        end else if (md == MODE_M1750_48 && $urandom_range(3) != 0) begin
            send_word({$urandom, $urandom}, 6);
        end else begin
            nseg = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
            for (int i = 0; i < nseg; i++) begin
                fb = 3'($urandom_range(7));
                lb = 3'($urandom_range(7));
                send_segment(8'($urandom_range(255)), fb, lb, i == nseg - 1);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = MODE_RAW;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        calm = 1'b0;
        seg_count = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty field, reversed range, extremes, overlong field.
        send_segment(8'hFF, 3'd5, 3'd2, 1'b1);
        send_segment(8'h00, 3'd0, 3'd7, 1'b1);
        send_segment(8'hFF, 3'd0, 3'd7, 1'b1);
        send_segment(8'h80, 3'd0, 3'd0, 1'b1);
        send_segment(8'h01, 3'd7, 3'd7, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 8);
        for (int i = 0; i < 9; i++) send_segment(8'hA5, 3'd0, 3'd7, i == 8);
        set_mode(MODE_TWOS);
        send_segment(8'hF0, 3'd0, 3'd3, 1'b1);
        send_word(64'h8000_0000_0000_0000, 8);
        set_mode(MODE_ONES);
        send_segment(8'hF0, 3'd0, 3'd3, 1'b1);
        send_segment(8'h00, 3'd3, 3'd1, 1'b1);
        set_mode(MODE_GRAY);
        send_word(64'hC000_0000_0000_0001, 8);
        set_mode(MODE_M1750_32);
        send_word(64'h4000_0001, 4);     // normal value
        send_word(64'h8000_0080, 4);     // most negative mantissa, smallest exponent
        send_word(64'h4000_0090, 4);     // negative exponent, still a normal value
        send_word(64'h0000_00FF, 4);     // zero mantissa
        set_mode(MODE_M1750_48);
        send_word(64'h4000_007F_FFFF, 6);
        send_word(64'h8000_0080_0000, 6);
        set_mode(3'd7);                  // unused mode behaves as raw
        send_word(64'h1234_5678, 4);

        // Random phases over every mode, the extremes among them.
        while (seg_count < 1200) begin
            logic [2:0] md;
            md = 3'($urandom_range(7));
            set_mode(md);
            calm = (seg_count > 500 && seg_count < 700);
            for (int f = 0; f < 40; f++) begin
                random_field(md);
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_fields != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS telemetry_field_decoder");
        end else begin
            $display("FAIL telemetry_field_decoder");
        end
        $finish;
    end
endmodule
